// ===== rtl/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg: shared types and constants for the cursor list engine
// Widths, opcodes, status codes and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
package clm_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;
	localparam int CNT_W    = 5;
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		OP_HEAD   = 3'd0,
		OP_TAIL   = 3'd1,
		OP_NEXT   = 3'd2,
		OP_BACK   = 3'd3,
		OP_APPEND = 3'd4,
		OP_REMOVE = 3'd5,
		OP_INSERT = 3'd6,
		OP_FIND   = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_INSERT = 2'd3
	} cell_cmd_t;

	typedef enum logic [3:0] {
		FSM_IDLE = 4'b0001,
		FSM_CMP  = 4'b0010,
		FSM_UPD  = 4'b0100,
		FSM_OUT  = 4'b1000
	} fsm_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic               cmp_en;
		logic [CNT_W-1:0]   count;
		logic [CNT_W-1:0]   pos;
		logic [WORD_W-1:0]  val;
	} cell_ctl_t;

endpackage

// ===== rtl/clm_cell.sv =====
// ----------------------------------------------------------------------------
// clm_cell: one list entry
// Holds a word, compares it with the search value, and on an update loads
// the new value or takes the word of its lower or upper neighbour.
// ----------------------------------------------------------------------------
module clm_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  clm_pkg::cell_ctl_t            ctl,
	input  logic [clm_pkg::WORD_W-1:0]    lower_word,
	input  logic [clm_pkg::WORD_W-1:0]    upper_word,
	output logic [clm_pkg::WORD_W-1:0]    word,
	output logic                          match
);

	localparam logic [clm_pkg::CNT_W-1:0] MY_IDX = clm_pkg::CNT_W'(IDX);

	logic [clm_pkg::WORD_W-1:0] word_q;
	logic                       match_q;
	logic [clm_pkg::WORD_W-1:0] word_d;

	always_comb begin
		word_d = word_q;
		case (ctl.cmd)
			clm_pkg::CMD_APPEND: begin
				if (MY_IDX == ctl.count) word_d = ctl.val;
			end
			clm_pkg::CMD_REMOVE: begin
				if (MY_IDX >= ctl.pos) word_d = upper_word;
			end
			clm_pkg::CMD_INSERT: begin
				if (MY_IDX == ctl.pos) word_d = ctl.val;
				else if (MY_IDX > ctl.pos) word_d = lower_word;
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		if (ctl.cmp_en) match_q <= (word_q == ctl.val);
	end

	assign word  = word_q;
	assign match = match_q;

endmodule

// ===== rtl/cursor_list_engine_core.sv =====
// sequence: an accepted beat passes the compare, update and output states, and its result
//   beat is registered on leaving the output state; the next beat is taken only after that,
//   once the output register has drained (s_tready stays low while the engine is busy)
// reset: arst_n clears count, cursor, sequencer and output valid; entries are unset
// ----------------------------------------------------------------------------
// cursor_list_engine_core: ordered list with cursor, built as a row of cells
// Each beat is one list operation; each operation returns one status beat.
// ----------------------------------------------------------------------------
module cursor_list_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], cursor[6:2], count[11:7], at_head[12],
	                               // at_tail[13], found[14], cursor_word[46:15], zero pad
);

	localparam int CAP  = clm_pkg::CAPACITY;
	localparam int CW   = clm_pkg::CNT_W;
	localparam int WW   = clm_pkg::WORD_W;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAP);

	clm_pkg::fsm_t            state_q;
	clm_pkg::opcode_t         op_q;
	logic [WW-1:0]            val_q;
	logic [CW-1:0]            pos_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            cursor_q;
	clm_pkg::status_t         status_q;
	logic                     found_q;
	logic                     m_tvalid_q;
	logic [47:0]              m_tdata_q;

	clm_pkg::cell_ctl_t       ctl;
	logic [WW-1:0]            words [CAP];
	logic [CAP-1:0]           match;
	logic [CAP-1:0]           hit_mask;
	logic [CW-1:0]            hit_idx;
	logic                     upd_ok;
	clm_pkg::cell_cmd_t       upd_cmd;
	clm_pkg::status_t         status_d;
	logic [CW-1:0]            cursor_d;
	logic [CW-1:0]            count_d;
	logic [WW-1:0]            cur_word;
	logic                     out_load;

	assign s_tready = (state_q == clm_pkg::FSM_IDLE);

	// row of cells, each fed by its neighbours
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [WW-1:0] lower_w;
		logic [WW-1:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_lower
			assign lower_w = words[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_upper
			assign upper_w = words[i+1];
		end
		clm_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (words[i]),
			.match      (match[i])
		);
	end

	// first matching entry at or after the cursor
	always_comb begin
		hit_idx = count_q;
		for (int i = 0; i < CAP; i++) begin
			hit_mask[i] = match[i] && (CW'(i) >= cursor_q) && (CW'(i) < count_q);
		end
		for (int i = CAP - 1; i >= 0; i--) begin
			if (hit_mask[i]) hit_idx = CW'(i);
		end
	end

	always_comb begin
		status_d = clm_pkg::ST_OK;
		cursor_d = cursor_q;
		count_d  = count_q;
		upd_cmd  = clm_pkg::CMD_NONE;
		upd_ok   = 1'b0;
		unique case (op_q)
			clm_pkg::OP_HEAD: cursor_d = '0;
			clm_pkg::OP_TAIL: cursor_d = count_q;
			clm_pkg::OP_NEXT: begin
				if (cursor_q < count_q) cursor_d = cursor_q + 1'b1;
			end
			clm_pkg::OP_BACK: begin
				if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
			end
			clm_pkg::OP_APPEND: begin
				if (count_q >= CAP_CNT) status_d = clm_pkg::ST_FULL;
				else begin
					upd_ok  = 1'b1;
					upd_cmd = clm_pkg::CMD_APPEND;
					count_d = count_q + 1'b1;
				end
			end
			clm_pkg::OP_REMOVE: begin
				if (pos_q >= count_q) status_d = clm_pkg::ST_RANGE;
				else begin
					upd_ok  = 1'b1;
					upd_cmd = clm_pkg::CMD_REMOVE;
					count_d = count_q - 1'b1;
					// keep cursor within the shortened list
					if (cursor_q > count_d) cursor_d = count_d;
				end
			end
			clm_pkg::OP_INSERT: begin
				if (pos_q > count_q) status_d = clm_pkg::ST_RANGE;
				else if (count_q >= CAP_CNT) status_d = clm_pkg::ST_FULL;
				else begin
					upd_ok  = 1'b1;
					upd_cmd = clm_pkg::CMD_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			clm_pkg::OP_FIND: cursor_d = hit_idx;
			default: cursor_d = cursor_q;
		endcase
	end

	always_comb begin
		ctl.cmd    = (state_q == clm_pkg::FSM_UPD && upd_ok) ? upd_cmd : clm_pkg::CMD_NONE;
		ctl.cmp_en = (state_q == clm_pkg::FSM_CMP);
		ctl.count  = count_q;
		ctl.pos    = pos_q;
		ctl.val    = val_q;
	end

	assign cur_word = (cursor_q < count_q) ? words[cursor_q[clm_pkg::IDX_W-1:0]] : '0;
	assign out_load = (state_q == clm_pkg::FSM_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= clm_pkg::FSM_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			unique case (state_q)
				clm_pkg::FSM_IDLE: begin
					if (s_tvalid) state_q <= clm_pkg::FSM_CMP;
				end
				clm_pkg::FSM_CMP: state_q <= clm_pkg::FSM_UPD;
				clm_pkg::FSM_UPD: begin
					count_q  <= count_d;
					cursor_q <= cursor_d;
					state_q  <= clm_pkg::FSM_OUT;
				end
				clm_pkg::FSM_OUT: begin
					if (out_load) state_q <= clm_pkg::FSM_IDLE;
				end
				default: state_q <= clm_pkg::FSM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= clm_pkg::opcode_t'(s_tuser);
			val_q <= s_tdata[31:0];
			pos_q <= s_tdata[36:32];
		end
		if (state_q == clm_pkg::FSM_UPD) begin
			status_q <= status_d;
			found_q  <= (op_q == clm_pkg::OP_FIND) && (|hit_mask);
		end
		if (out_load) begin
			m_tdata_q <= {1'b0, cur_word, found_q, (cursor_q == count_q),
			              (cursor_q == '0), count_q, cursor_q, status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/clm_checker.sv =====
// ----------------------------------------------------------------------------
// clm_checker: port-level checks for the cursor list engine
// Watches result beats for consistency of cursor, count and flags.
// ----------------------------------------------------------------------------
module clm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[12] == (m_tdata[6:2] == 5'd0)) &&
		             (m_tdata[13] == (m_tdata[6:2] == m_tdata[11:7])))
		else $error("head or tail flag disagrees with cursor");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:2] <= m_tdata[11:7]) && (m_tdata[11:7] <= 5'd16) &&
		             (m_tdata[1:0] != 2'd3))
		else $error("cursor, count or status out of range");

	// a hit leaves the cursor on a live entry
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[1:0] == 2'd0 && !m_tdata[13])
		else $error("found flagged with cursor at tail");

	// word past the end reads as zero
	a_tail_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[46:15] == 32'd0)
		else $error("nonzero word at tail");

endmodule

bind cursor_list_engine_core clm_checker u_clm_checker (.*);

// ===== verif/cursor_list_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_list_engine_core_tb: self-checking bench for the cursor list engine
// Drives list operations as stream beats, with bursty input and a stalling
// output, and checks every status beat against a behavioural list model or a fixed expectation.
// ----------------------------------------------------------------------------
module cursor_list_engine_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1600;
	localparam int IDLE_LIMIT = 5000;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		clm_pkg::status_t           status;
		logic [clm_pkg::CNT_W-1:0]  cursor;
		logic [clm_pkg::CNT_W-1:0]  count;
		logic                       at_head;
		logic                       at_tail;
		logic                       found;
		logic [clm_pkg::WORD_W-1:0] word;
	} list_result_t;

	typedef struct packed {
		clm_pkg::opcode_t           op;
		logic [clm_pkg::WORD_W-1:0] val;
		logic [4:0]                 pos;
		logic [4:0]                 reps;
		logic                       typed;
		list_result_t               exp;
	} stim_row_t;

	localparam list_result_t EMPTY_OK = '{status: clm_pkg::ST_OK, cursor: 5'd0, count: 5'd0,
		at_head: 1'b1, at_tail: 1'b1, found: 1'b0, word: 32'd0};
	localparam list_result_t EMPTY_RANGE = '{status: clm_pkg::ST_RANGE, cursor: 5'd0,
		count: 5'd0, at_head: 1'b1, at_tail: 1'b1, found: 1'b0, word: 32'd0};
	localparam list_result_t ONE_MIN = '{status: clm_pkg::ST_OK, cursor: 5'd0, count: 5'd1,
		at_head: 1'b1, at_tail: 1'b0, found: 1'b0, word: 32'h8000_0000};
	localparam list_result_t NO_EXP = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	// model of the list contents, length and cursor
	logic [clm_pkg::WORD_W-1:0] list_words [0:clm_pkg::CAPACITY-1];
	int                         list_len = 0;
	int                         list_cur = 0;

	list_result_t due_results [$];
	int           errors = 0;
	int           burst_left = 0;
	int           idle_cycles = 0;
	int           cyc = 0;
	int           stall_mode = 0;

	cursor_list_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic list_result_t apply_list_op(clm_pkg::opcode_t op,
			logic [clm_pkg::WORD_W-1:0] val, logic [4:0] pos);
		list_result_t r;
		int           i;
		logic         hit;
		r = '0;
		r.status = clm_pkg::ST_OK;
		hit = 1'b0;
		case (op)
			clm_pkg::OP_HEAD: list_cur = 0;
			clm_pkg::OP_TAIL: list_cur = list_len;
			clm_pkg::OP_NEXT: if (list_cur < list_len) list_cur++;
			clm_pkg::OP_BACK: if (list_cur > 0) list_cur--;
			clm_pkg::OP_APPEND: begin
				if (list_len >= clm_pkg::CAPACITY) begin
					r.status = clm_pkg::ST_FULL;
				end else begin
					list_words[list_len] = val;
					list_len++;
				end
			end
			clm_pkg::OP_REMOVE: begin
				if (int'(pos) >= list_len) begin
					r.status = clm_pkg::ST_RANGE;
				end else begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
					if (list_cur > list_len) list_cur = list_len;
				end
			end
			clm_pkg::OP_INSERT: begin
				// range check wins over the full check
				if (int'(pos) > list_len) begin
					r.status = clm_pkg::ST_RANGE;
				end else if (list_len >= clm_pkg::CAPACITY) begin
					r.status = clm_pkg::ST_FULL;
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_words[i] = list_words[i-1];
					list_words[pos] = val;
					list_len++;
				end
			end
			default: begin
				// search from the cursor, land on the match or on the tail
				i = list_cur;
				while (i < list_len && !hit) begin
					if (list_words[i] == val) hit = 1'b1;
					else i++;
				end
				list_cur = i;
			end
		endcase
		r.cursor  = list_cur[clm_pkg::CNT_W-1:0];
		r.count   = list_len[clm_pkg::CNT_W-1:0];
		r.at_head = (list_cur == 0);
		r.at_tail = (list_cur == list_len);
		r.found   = hit;
		r.word    = (list_cur < list_len) ? list_words[list_cur] : '0;
		return r;
	endfunction

	// one input beat: optional gap, hold until accepted, then book the result
	task automatic send_op(clm_pkg::opcode_t op, logic [clm_pkg::WORD_W-1:0] val,
			logic [4:0] pos, logic typed, list_result_t exp);
		int           gap;
		list_result_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end else begin
			gap = 0;
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, pos, val};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pred = apply_list_op(op, val, pos);
		due_results.push_back(typed ? exp : pred);
	endtask

	// receiver back-pressure, in one of four modes that is picked anew at random during the run
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 128 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 2) == 0);
			2: m_tready <= (cyc % 11) < 7;
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status  = clm_pkg::status_t'(m_tdata[1:0]);
			got.cursor  = m_tdata[6:2];
			got.count   = m_tdata[11:7];
			got.at_head = m_tdata[12];
			got.at_tail = m_tdata[13];
			got.found   = m_tdata[14];
			got.word    = m_tdata[46:15];
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected result beat: tdata=%h", m_tdata);
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_SHOWN) begin
						$display("mismatch: exp st=%0d cur=%0d cnt=%0d h=%b t=%b f=%b w=%h",
							want.status, want.cursor, want.count, want.at_head,
							want.at_tail, want.found, want.word);
						$display("          got st=%0d cur=%0d cnt=%0d h=%b t=%b f=%b w=%h",
							got.status, got.cursor, got.count, got.at_head,
							got.at_tail, got.found, got.word);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t                  dir_rows [0:24];
		clm_pkg::opcode_t           op;
		logic [clm_pkg::WORD_W-1:0] val;
		logic [4:0]                 pos;
		int                         r;
		int                         n;
		bit                         grow;

		dir_rows = '{
			'{clm_pkg::OP_HEAD,   32'h0000_0000, 5'd0,  5'd1,  1'b1, EMPTY_OK},
			'{clm_pkg::OP_BACK,   32'h0000_0000, 5'd0,  5'd1,  1'b1, EMPTY_OK}, // back at head
			'{clm_pkg::OP_NEXT,   32'h0000_0000, 5'd0,  5'd1,  1'b1, EMPTY_OK}, // next at tail
			'{clm_pkg::OP_REMOVE, 32'h0000_0000, 5'd0,  5'd1,  1'b1, EMPTY_RANGE},
			'{clm_pkg::OP_INSERT, 32'h0000_0000, 5'd1,  5'd1,  1'b1, EMPTY_RANGE},
			'{clm_pkg::OP_FIND,   32'h0000_0000, 5'd0,  5'd1,  1'b1, EMPTY_OK},
			'{clm_pkg::OP_APPEND, 32'h8000_0000, 5'd0,  5'd1,  1'b1, ONE_MIN},
			'{clm_pkg::OP_APPEND, 32'h7fff_ffff, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_INSERT, 32'hffff_ffff, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_INSERT, 32'h0000_0000, 5'd3,  5'd1,  1'b0, NO_EXP}, // insert at the end
			'{clm_pkg::OP_TAIL,   32'h0000_0000, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_NEXT,   32'h0000_0000, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_BACK,   32'h0000_0000, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_FIND,   32'h8000_0000, 5'd0,  5'd1,  1'b0, NO_EXP}, // no match past cursor
			'{clm_pkg::OP_HEAD,   32'h0000_0000, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_FIND,   32'h7fff_ffff, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_REMOVE, 32'h0000_0000, 5'd4,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_TAIL,   32'h0000_0000, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_REMOVE, 32'h0000_0000, 5'd3,  5'd1,  1'b0, NO_EXP}, // cursor gets clamped
			'{clm_pkg::OP_APPEND, 32'h5a5a_5a5a, 5'd0,  5'd13, 1'b0, NO_EXP}, // fill to capacity
			'{clm_pkg::OP_APPEND, 32'h0000_0001, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_INSERT, 32'h0000_0002, 5'd16, 5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_INSERT, 32'h0000_0003, 5'd0,  5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_REMOVE, 32'h0000_0000, 5'd16, 5'd1,  1'b0, NO_EXP},
			'{clm_pkg::OP_REMOVE, 32'h0000_0000, 5'd0,  5'd1,  1'b0, NO_EXP}
		};

		for (int k = 0; k < clm_pkg::CAPACITY; k++) list_words[k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			for (int j = 0; j < dir_rows[k].reps; j++)
				send_op(dir_rows[k].op, dir_rows[k].val, dir_rows[k].pos,
					dir_rows[k].typed, dir_rows[k].exp);

		for (n = 0; n < N_RANDOM; n++) begin
			// hold off until the engine has drained everything
			if (n == N_RANDOM / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (due_results.size() != 0);
			end
			// alternate between filling and draining the list
			grow = ((n / 150) % 2) == 0;
			r = $urandom_range(0, 99);
			if (grow) begin
				if (r < 30)      op = clm_pkg::OP_APPEND;
				else if (r < 55) op = clm_pkg::OP_INSERT;
				else if (r < 65) op = clm_pkg::OP_REMOVE;
				else if (r < 75) op = clm_pkg::OP_FIND;
				else             op = clm_pkg::opcode_t'($urandom_range(0, 3));
			end else begin
				if (r < 35)      op = clm_pkg::OP_REMOVE;
				else if (r < 45) op = clm_pkg::OP_APPEND;
				else if (r < 55) op = clm_pkg::OP_INSERT;
				else if (r < 70) op = clm_pkg::OP_FIND;
				else             op = clm_pkg::opcode_t'($urandom_range(0, 3));
			end
			// small pool so finds hit, with extremes and full-width noise
			case ($urandom_range(0, 9))
				0: val = 32'h0000_0000;
				1: val = 32'hffff_ffff;
				2: val = 32'h8000_0000;
				3: val = 32'h7fff_ffff;
				4: val = 32'h0000_0001;
				5: val = 32'h5a5a_5a5a;
				default: val = $urandom;
			endcase
			if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(0, list_len));
			else                            pos = 5'($urandom_range(0, clm_pkg::CAPACITY));
			send_op(op, val, pos, 1'b0, NO_EXP);
		end

		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else             $display("status: fail");
		$finish;
	end

endmodule
